>>> rtl/segment_closest_points_defines.svh
// Assertion macros for the segment closest-points block.
// Used by files that place concurrent checks on clk_i and rst_ni.
`ifndef SEGMENT_CLOSEST_POINTS_DEFINES_SVH
`define SEGMENT_CLOSEST_POINTS_DEFINES_SVH

// Checks a property on every rising clk_i edge outside reset.
`define SCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define SCP_ASSERT_IMPL(lbl, ante, cons, msg) \
  `SCP_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> rtl/scp_pkg.sv
// Package for the segment closest-points block: formats, widths and beat types.
// No dependencies.
package scp_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  localparam int DW  = COORD_WIDTH + 1;   // coordinate difference
  localparam int PW  = 2 * DW + 2;        // dot product of two differences
  localparam int LB  = (PW + 1) / 2;      // limb width for wide products
  localparam int QW  = 2 * PW + 1;        // determinant and numerators
  localparam int RW  = QW + 1;            // divider remainder
  localparam int PRW = FRAC_BITS + 1;     // clamped parameter, 0 .. 1.0
  localparam int PLW = PRW + DW + 1;      // parameter times direction

  localparam logic [PRW-1:0] PAR_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_start_z;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t a_end_z;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_start_z;
    coord_t b_end_x;
    coord_t b_end_y;
    coord_t b_end_z;
  } in_t;

  typedef struct packed {
    coord_t near_a_x;
    coord_t near_a_y;
    coord_t near_a_z;
    coord_t near_b_x;
    coord_t near_b_y;
    coord_t near_b_z;
    logic   degenerate;
  } out_t;

endpackage

>>> rtl/segment_closest_points.sv
// Top level of the segment closest-points block: a fully pipelined datapath.
// Depends on scp_pkg and on segment_closest_points_defines.svh.
//
// Usage: each input beat on in_data_i carries two 3D segments in signed Q16.16.
// Each output beat on out_data_o carries the nearest point on each segment to
// the other, saturated to the coordinate range, plus a degenerate flag that is
// set when the segments are parallel and the parallel divisor is zero as well.
// Both channels use valid and stall; a beat moves on an edge with valid high
// and stall low. Every input beat yields exactly one output beat, in order.
// The pipeline has FRAC_BITS + 9 register stages, and a new beat is accepted
// every cycle while out_stall_i is low; the depth is set by the five dot
// products, the split 68-bit products, and one restoring divider stage per
// fraction bit of the two clamped parameters.
// Every stage has its own valid bit and loads when it is empty or when the
// stage after it moves, so bubbles close up while the receiver stalls; when
// all stages are full, in_stall_o follows out_stall_i in the same cycle.
// Reset empties the pipeline; results in flight are dropped and the block
// accepts a beat in the first cycle after reset is released.
`include "segment_closest_points_defines.svh"

module segment_closest_points (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  scp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output scp_pkg::out_t out_data_o
);
  import scp_pkg::*;

  // Stage positions along the pipeline.
  localparam int S_DIFF = 0;
  localparam int S_PROD = 1;
  localparam int S_DOT  = 2;
  localparam int S_PP   = 3;
  localparam int S_WIDE = 4;
  localparam int S_NUM  = 5;
  localparam int S_PREP = 6;
  localparam int S_DIV0 = 7;
  localparam int S_MUL  = S_DIV0 + FRAC_BITS;
  localparam int S_OUT  = S_MUL + 1;
  localparam int NS     = S_OUT + 1;

  // Dot product slots.
  localparam int D_AA = 0;
  localparam int D_BB = 1;
  localparam int D_AB = 2;
  localparam int D_RA = 3;
  localparam int D_RB = 4;

  // Wide product slots.
  localparam int M_ABAB = 0;
  localparam int M_BBAA = 1;
  localparam int M_RBAB = 2;
  localparam int M_BBRA = 3;
  localparam int M_AARB = 4;
  localparam int M_RAAB = 5;

  typedef logic signed [DW-1:0]     diff_t;
  typedef logic signed [2*DW-1:0]   prod_t;
  typedef logic signed [PW-1:0]     dot_t;
  typedef logic signed [LB:0]       limb_t;
  typedef logic signed [2*LB+1:0]   part_t;
  typedef logic signed [QW-1:0]     quo_t;
  typedef logic        [PRW-1:0]    par_t;
  typedef logic signed [PLW-1:0]    mul_t;
  typedef logic signed [PLW:0]      rnd_t;
  typedef logic signed [PLW+1:0]    sum_t;

  typedef struct packed {
    part_t hh;
    part_t hl;
    part_t lh;
    part_t ll;
  } pp_t;

  typedef struct packed {
    logic [RW-1:0]        rem;
    logic [RW-1:0]        den;
    logic [FRAC_BITS-1:0] q;
    logic                 zero;
    logic                 one;
  } div_t;

  typedef struct packed {
    coord_t [2:0] as;
    coord_t [2:0] bs;
    diff_t  [2:0] da;
    diff_t  [2:0] db;
    logic         deg;
  } geo_t;

  // A 2-limb signed product split into four narrow partial products.
  function automatic pp_t wide_pp(dot_t x, dot_t y);
    pp_t   p;
    limb_t xh, xl, yh, yl;
    xh = limb_t'(signed'(x[PW-1:LB]));
    yh = limb_t'(signed'(y[PW-1:LB]));
    xl = limb_t'({1'b0, x[LB-1:0]});
    yl = limb_t'({1'b0, y[LB-1:0]});
    p.hh = part_t'(xh) * part_t'(yh);
    p.hl = part_t'(xh) * part_t'(yl);
    p.lh = part_t'(xl) * part_t'(yh);
    p.ll = part_t'(xl) * part_t'(yl);
    return p;
  endfunction

  function automatic quo_t wide_sum(pp_t p);
    return (quo_t'(p.hh) <<< (2 * LB)) + ((quo_t'(p.hl) + quo_t'(p.lh)) <<< LB)
           + quo_t'(p.ll);
  endfunction

  // Moves the sign into the numerator and settles the clamped ends.
  function automatic div_t div_prep(quo_t num, quo_t den, logic zf);
    div_t r;
    quo_t n, d;
    n = den[QW-1] ? -num : num;
    d = den[QW-1] ? -den : den;
    r.zero = zf || n[QW-1] || (n == '0);
    r.one  = !r.zero && (n >= d);
    r.rem  = {1'b0, n};
    r.den  = {1'b0, d};
    r.q    = '0;
    return r;
  endfunction

  // One restoring division step: one quotient bit.
  function automatic div_t div_step(div_t x);
    div_t          r;
    logic [RW-1:0] sh;
    r  = x;
    sh = {x.rem[RW-2:0], 1'b0};
    if (sh >= x.den) begin
      r.rem = sh - x.den;
      r.q   = {x.q[FRAC_BITS-2:0], 1'b1};
    end else begin
      r.rem = sh;
      r.q   = {x.q[FRAC_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic par_t div_par(div_t x);
    if (x.zero) begin
      return '0;
    end else if (x.one) begin
      return PAR_ONE;
    end else begin
      return {1'b0, x.q};
    end
  endfunction

  // base + round(mul >> FRAC_BITS), saturated to the coordinate range.
  function automatic coord_t place(coord_t base, mul_t m);
    rnd_t half, rnd;
    sum_t s, smax, smin;
    half = '0;
    half[FRAC_BITS-1] = 1'b1;
    rnd  = rnd_t'(m) + half;
    rnd  = rnd >>> FRAC_BITS;
    s    = sum_t'(base) + sum_t'(rnd);
    smax = sum_t'(signed'({1'b0, {(COORD_WIDTH-1){1'b1}}}));
    smin = sum_t'(signed'({1'b1, {(COORD_WIDTH-1){1'b0}}}));
    if (s > smax) begin
      return smax[COORD_WIDTH-1:0];
    end else if (s < smin) begin
      return smin[COORD_WIDTH-1:0];
    end else begin
      return s[COORD_WIDTH-1:0];
    end
  endfunction

  // Handshake: a stage loads when it is empty or its successor moves.
  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = !out_stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_d = {v_q[NS-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[S_OUT];

  // Payload registers.
  geo_t          geo_q   [S_OUT];
  diff_t [2:0]   rr_q;
  prod_t [14:0]  prod_q;
  dot_t  [4:0]   dot_q;
  pp_t   [5:0]   pp_q;
  dot_t  [1:0]   keep_pp_q;
  quo_t  [5:0]   wide_q;
  dot_t  [1:0]   keep_wide_q;
  quo_t          snum_q, sden_q, tnum_q, tden_q;
  logic          szf_q, tzf_q;
  div_t          div_s_q [FRAC_BITS+1];
  div_t          div_t_q [FRAC_BITS+1];
  mul_t  [5:0]   mul_q;
  out_t          out_q;

  // Next values of the arithmetic stages.
  geo_t          geo_d;
  geo_t          geo_num_d;
  diff_t [2:0]   rr_d;
  prod_t [14:0]  prod_d;
  dot_t  [4:0]   dot_d;
  pp_t   [5:0]   pp_d;
  quo_t  [5:0]   wide_d;
  quo_t          snum_d, sden_d, tnum_d, tden_d;
  logic          szf_d, tzf_d, par_d;
  mul_t  [5:0]   mul_d;
  out_t          out_d;
  par_t          sa, tb;

  always_comb begin
    coord_t [2:0] ae, be;
    geo_d.as = {in_data_i.a_start_z, in_data_i.a_start_y, in_data_i.a_start_x};
    geo_d.bs = {in_data_i.b_start_z, in_data_i.b_start_y, in_data_i.b_start_x};
    ae       = {in_data_i.a_end_z, in_data_i.a_end_y, in_data_i.a_end_x};
    be       = {in_data_i.b_end_z, in_data_i.b_end_y, in_data_i.b_end_x};
    geo_d.deg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      geo_d.da[i] = diff_t'(ae[i]) - diff_t'(geo_d.as[i]);
      geo_d.db[i] = diff_t'(be[i]) - diff_t'(geo_d.bs[i]);
      rr_d[i]     = diff_t'(geo_d.bs[i]) - diff_t'(geo_d.as[i]);
    end
  end

  // Fifteen coordinate products, three per dot product.
  always_comb begin
    geo_t g;
    g = geo_q[S_DIFF];
    for (int i = 0; i < 3; i++) begin
      prod_d[3*D_AA+i] = prod_t'(g.da[i]) * prod_t'(g.da[i]);
      prod_d[3*D_BB+i] = prod_t'(g.db[i]) * prod_t'(g.db[i]);
      prod_d[3*D_AB+i] = prod_t'(g.db[i]) * prod_t'(g.da[i]);
      prod_d[3*D_RA+i] = prod_t'(rr_q[i]) * prod_t'(g.da[i]);
      prod_d[3*D_RB+i] = prod_t'(rr_q[i]) * prod_t'(g.db[i]);
    end
  end

  always_comb begin
    for (int d = 0; d < 5; d++) begin
      dot_d[d] = dot_t'(prod_q[3*d]) + dot_t'(prod_q[3*d+1]) + dot_t'(prod_q[3*d+2]);
    end
  end

  always_comb begin
    pp_d[M_ABAB] = wide_pp(dot_q[D_AB], dot_q[D_AB]);
    pp_d[M_BBAA] = wide_pp(dot_q[D_BB], dot_q[D_AA]);
    pp_d[M_RBAB] = wide_pp(dot_q[D_RB], dot_q[D_AB]);
    pp_d[M_BBRA] = wide_pp(dot_q[D_BB], dot_q[D_RA]);
    pp_d[M_AARB] = wide_pp(dot_q[D_AA], dot_q[D_RB]);
    pp_d[M_RAAB] = wide_pp(dot_q[D_RA], dot_q[D_AB]);
  end

  always_comb begin
    for (int m = 0; m < 6; m++) begin
      wide_d[m] = wide_sum(pp_q[m]);
    end
  end

  // Picks the general or the parallel-segment quotients.
  always_comb begin
    dot_t ab, ra;
    ab    = keep_wide_q[0];
    ra    = keep_wide_q[1];
    par_d = (wide_q[M_ABAB] == wide_q[M_BBAA]);
    sden_d = wide_q[M_ABAB] - wide_q[M_BBAA];
    snum_d = wide_q[M_RBAB] - wide_q[M_BBRA];
    szf_d  = par_d;
    if (par_d) begin
      tnum_d = -quo_t'(ra);
      tden_d = quo_t'(ab);
      tzf_d  = (ab == '0);
    end else begin
      tnum_d = wide_q[M_AARB] - wide_q[M_RAAB];
      tden_d = sden_d;
      tzf_d  = 1'b0;
    end
  end

  // The degenerate flag joins the geometry when the quotients are picked.
  always_comb begin
    geo_num_d     = geo_q[S_NUM-1];
    geo_num_d.deg = tzf_d;
  end

  always_comb begin
    geo_t g;
    g  = geo_q[S_MUL-1];
    sa = div_par(div_s_q[FRAC_BITS]);
    tb = div_par(div_t_q[FRAC_BITS]);
    for (int i = 0; i < 3; i++) begin
      mul_d[i]   = mul_t'(signed'({1'b0, sa})) * mul_t'(g.da[i]);
      mul_d[3+i] = mul_t'(signed'({1'b0, tb})) * mul_t'(g.db[i]);
    end
  end

  always_comb begin
    geo_t g;
    g = geo_q[S_MUL];
    out_d.near_a_x   = place(g.as[0], mul_q[0]);
    out_d.near_a_y   = place(g.as[1], mul_q[1]);
    out_d.near_a_z   = place(g.as[2], mul_q[2]);
    out_d.near_b_x   = place(g.bs[0], mul_q[3]);
    out_d.near_b_y   = place(g.bs[1], mul_q[4]);
    out_d.near_b_z   = place(g.bs[2], mul_q[5]);
    out_d.degenerate = g.deg;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[S_DIFF]) begin
      geo_q[S_DIFF] <= geo_d;
      rr_q          <= rr_d;
    end
    for (int k = 1; k < S_OUT; k++) begin
      if (rdy[k]) begin
        if (k == S_NUM) begin
          geo_q[k] <= geo_num_d;
        end else begin
          geo_q[k] <= geo_q[k-1];
        end
      end
    end
    if (rdy[S_PROD]) begin
      prod_q <= prod_d;
    end
    if (rdy[S_DOT]) begin
      dot_q <= dot_d;
    end
    if (rdy[S_PP]) begin
      pp_q      <= pp_d;
      keep_pp_q <= {dot_q[D_RA], dot_q[D_AB]};
    end
    if (rdy[S_WIDE]) begin
      wide_q      <= wide_d;
      keep_wide_q <= keep_pp_q;
    end
    if (rdy[S_NUM]) begin
      snum_q <= snum_d;
      sden_q <= sden_d;
      tnum_q <= tnum_d;
      tden_q <= tden_d;
      szf_q  <= szf_d;
      tzf_q  <= tzf_d;
    end
    if (rdy[S_PREP]) begin
      div_s_q[0] <= div_prep(snum_q, sden_q, szf_q);
      div_t_q[0] <= div_prep(tnum_q, tden_q, tzf_q);
    end
    // Slot j of the divider arrays belongs to stage S_PREP + j.
    for (int j = 1; j <= FRAC_BITS; j++) begin
      if (rdy[S_PREP+j]) begin
        div_s_q[j] <= div_step(div_s_q[j-1]);
        div_t_q[j] <= div_step(div_t_q[j-1]);
      end
    end
    if (rdy[S_MUL]) begin
      mul_q <= mul_d;
    end
    if (rdy[S_OUT]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  `SCP_ASSERT_IMPL(a_empty_head_takes, !v_q[S_DIFF], !in_stall_o,
                   "input stalled while the first stage is empty")
  `SCP_ASSERT_IMPL(a_rem_below_den, v_q[S_MUL-1] && !div_s_q[FRAC_BITS].zero
                   && !div_s_q[FRAC_BITS].one,
                   div_s_q[FRAC_BITS].rem < div_s_q[FRAC_BITS].den,
                   "divider remainder reached the divisor")
  `SCP_ASSERT_IMPL(a_degenerate_zero_t, v_q[S_MUL-1] && geo_q[S_MUL-1].deg,
                   div_t_q[FRAC_BITS].zero, "degenerate beat without a zero parameter")
  `SCP_ASSERT(a_clamp_ends_exclusive,
              !(v_q[S_MUL-1] && div_s_q[FRAC_BITS].zero && div_s_q[FRAC_BITS].one),
              "parameter clamped to both ends")

endmodule

>>> verif/tb_segment_closest_points.sv
// Testbench for the segment closest-points block: a self-checking random and directed run.
// Depends on scp_pkg and the segment_closest_points top level; needs nothing else.
module tb_segment_closest_points;
  import scp_pkg::*;

  // Wide enough for the determinant times a parameter; values stay far below this.
  typedef logic signed [299:0] big_t;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_stall_o;
  in_t   in_data_i;
  logic  out_valid_o;
  logic  out_stall_i;
  out_t  out_data_o;

  segment_closest_points dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  localparam int LATENCY  = FRAC_BITS + 9;
  localparam int WDOG_MAX = 2000;

  in_t  pending_pairs[$];
  out_t expected_points[$];
  int   errors;
  int   quiet_cycles;
  bit   stim_done;
  bit   calm;          // set for the tail of the run: no idling on either side
  int   send_gap;
  int   recv_gap;
  int   hold_left;     // long receiver hold-off, counted down in the receiver process
  int   pairs_sent;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Clamp num/den into [0,1] as unsigned Q1.F, truncated toward zero.
  function automatic logic [PRW-1:0] clamped_ratio(big_t num, big_t den);
    big_t q;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return '0;
    if (num >= den) return PAR_ONE;
    q = (num <<< FRAC_BITS) / den;
    return q[PRW-1:0];
  endfunction

  // start + round(par * dir), saturated to the coordinate range.
  function automatic coord_t move_along(big_t base, big_t dir, logic [PRW-1:0] par);
    big_t v;
    big_t hi;
    big_t lo;
    hi = (big_t'(1) <<< (COORD_WIDTH - 1)) - 1;
    lo = -(big_t'(1) <<< (COORD_WIDTH - 1));
    v = base + ((big_t'(par) * dir + (big_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[COORD_WIDTH-1:0];
  endfunction

  // Nearest points between the two segments of one beat.
  function automatic out_t nearest_points(in_t p);
    big_t as[3], bs[3], da[3], db[3], rr[3];
    big_t aa, bb, ab, ra, rb, det;
    logic [PRW-1:0] sa, tb;
    out_t r;
    as[0] = p.a_start_x; as[1] = p.a_start_y; as[2] = p.a_start_z;
    bs[0] = p.b_start_x; bs[1] = p.b_start_y; bs[2] = p.b_start_z;
    da[0] = big_t'(p.a_end_x) - as[0];
    da[1] = big_t'(p.a_end_y) - as[1];
    da[2] = big_t'(p.a_end_z) - as[2];
    db[0] = big_t'(p.b_end_x) - bs[0];
    db[1] = big_t'(p.b_end_y) - bs[1];
    db[2] = big_t'(p.b_end_z) - bs[2];
    for (int k = 0; k < 3; k++) rr[k] = bs[k] - as[k];
    aa = da[0] * da[0] + da[1] * da[1] + da[2] * da[2];
    bb = db[0] * db[0] + db[1] * db[1] + db[2] * db[2];
    ab = db[0] * da[0] + db[1] * da[1] + db[2] * da[2];
    ra = rr[0] * da[0] + rr[1] * da[1] + rr[2] * da[2];
    rb = rr[0] * db[0] + rr[1] * db[1] + rr[2] * db[2];
    det = ab * ab - bb * aa;
    r.degenerate = 1'b0;
    if (det == 0) begin
      // Parallel segments: pin A at its start and project onto B.
      sa = '0;
      if (ab == 0) begin
        tb = '0;
        r.degenerate = 1'b1;
      end else begin
        tb = clamped_ratio(-ra, ab);
      end
    end else begin
      sa = clamped_ratio(rb * ab - bb * ra, det);
      tb = clamped_ratio(aa * rb - ra * ab, det);
    end
    r.near_a_x = move_along(as[0], da[0], sa);
    r.near_a_y = move_along(as[1], da[1], sa);
    r.near_a_z = move_along(as[2], da[2], sa);
    r.near_b_x = move_along(bs[0], db[0], tb);
    r.near_b_y = move_along(bs[1], db[1], tb);
    r.near_b_z = move_along(bs[2], db[2], tb);
    return r;
  endfunction

  // A coordinate that is often near an edge, often small, otherwise fully random.
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFFFFFF - $urandom_range(0, 3);
      1: return 32'sh80000000 + $urandom_range(0, 3);
      2, 3: return coord_t'($signed($urandom_range(0, 40 << FRAC_BITS)) - (20 << FRAC_BITS));
      4: return coord_t'($signed($urandom_range(0, 40)) - 20) <<< FRAC_BITS;
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic in_t random_pair();
    in_t p;
    coord_t dx, dy, dz;
    int  sc;
    p = in_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    case ($urandom_range(0, 5))
      0: ;  // fully random bits
      1: begin
        // Parallel segments: B's direction is a multiple of A's.
        dx = coord_t'($signed($urandom_range(0, 200)) - 100) <<< 10;
        dy = coord_t'($signed($urandom_range(0, 200)) - 100) <<< 10;
        dz = coord_t'($signed($urandom_range(0, 200)) - 100) <<< 10;
        sc = $signed($urandom_range(0, 6)) - 3;
        p.a_start_x = pick_coord() >>> 4; p.a_start_y = pick_coord() >>> 4;
        p.a_start_z = pick_coord() >>> 4;
        p.a_end_x = p.a_start_x + dx; p.a_end_y = p.a_start_y + dy;
        p.a_end_z = p.a_start_z + dz;
        p.b_start_x = pick_coord() >>> 4; p.b_start_y = pick_coord() >>> 4;
        p.b_start_z = pick_coord() >>> 4;
        p.b_end_x = p.b_start_x + dx * sc; p.b_end_y = p.b_start_y + dy * sc;
        p.b_end_z = p.b_start_z + dz * sc;
      end
      default: begin
        p.a_start_x = pick_coord(); p.a_start_y = pick_coord(); p.a_start_z = pick_coord();
        p.a_end_x = pick_coord();   p.a_end_y = pick_coord();   p.a_end_z = pick_coord();
        p.b_start_x = pick_coord(); p.b_start_y = pick_coord(); p.b_start_z = pick_coord();
        p.b_end_x = pick_coord();   p.b_end_y = pick_coord();   p.b_end_z = pick_coord();
      end
    endcase
    return p;
  endfunction

  function automatic in_t make_pair(int ax0, int ay0, int az0, int ax1, int ay1, int az1,
                                    int bx0, int by0, int bz0, int bx1, int by1, int bz1);
    in_t p;
    p.a_start_x = ax0; p.a_start_y = ay0; p.a_start_z = az0;
    p.a_end_x = ax1;   p.a_end_y = ay1;   p.a_end_z = az1;
    p.b_start_x = bx0; p.b_start_y = by0; p.b_start_z = bz0;
    p.b_end_x = bx1;   p.b_end_y = by1;   p.b_end_z = bz1;
    return p;
  endfunction

  // Sender: offers the head of the queue, with random bursts of idle cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_points.push_back(nearest_points(in_data_i));
        pairs_sent <= pairs_sent + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_pairs.pop_front();
          if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 5);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap    <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_data_o);
          errors++;
        end else begin
          out_t e;
          e = expected_points.pop_front();
          if (e !== out_data_o) begin
            $display("%0t: mismatch expected %h actual %h", $time, e, out_data_o);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap    <= recv_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 5);
      end
    end
  end

  // Watchdog: cycles in a row with no beat moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    localparam int ONE = 1 << FRAC_BITS;
    errors = 0; quiet_cycles = 0; stim_done = 0; calm = 0;
    hold_left = 0; pairs_sent = 0;
    in_valid_i = 1'b0; in_data_i = '0; out_stall_i = 1'b0;
    rst_ni = 1'b0;

    // Directed beats: crossing, parallel, both-points, clamps and extremes.
    pending_pairs.push_back(make_pair(0, 0, 0, ONE, 0, 0, 0, -ONE, ONE, 0, ONE, ONE));
    pending_pairs.push_back(make_pair(-ONE, 0, 0, ONE, 0, 0, 0, -ONE, 0, 0, ONE, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, ONE, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 2 * ONE, 0, 0, 3 * ONE, ONE, 0, 5 * ONE, ONE,
                                      0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0, ONE, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, ONE, 0, 0, 5, 5, 5, 5, 5, 5));
    pending_pairs.push_back(make_pair(5 * ONE, 0, 0, 6 * ONE, 0, 0, 0, -ONE, 0, 0, ONE, 0));
    pending_pairs.push_back(make_pair(-6 * ONE, 0, 0, -5 * ONE, 0, 0, 0, 0, -ONE, 0, 0,
                                      ONE));
    pending_pairs.push_back(make_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                      32'h80000000, 32'h80000000, 32'h80000000,
                                      32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                      32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    pending_pairs.push_back(make_pair(32'h80000000, 32'h80000000, 32'h80000000,
                                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                      32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                                      32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF));
    pending_pairs.push_back(make_pair(32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0,
                                      32'h7FFFFFFF, 1, 0, 32'h80000000, 1, 0));
    pending_pairs.push_back(make_pair(-1, -1, -1, 1, 1, 1, 1, -1, 0, -1, 1, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 3, 7, 1, 2, 0, 5, 9, 1, 2));
    pending_pairs.push_back(make_pair(32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, ONE, 0,
                                      32'h7FFFFFFF, 0, ONE, 32'h7FFFFFFF, ONE, ONE));
    for (int i = 0; i < 600; i++) pending_pairs.push_back(random_pair());

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // One long receiver hold-off while the sender keeps offering, to fill the pipe.
    wait (pairs_sent >= 40);
    @(posedge clk_i);
    hold_left <= 3 * LATENCY + 20;

    wait (pending_pairs.size() < 60);
    @(posedge clk_i);
    calm <= 1'b1;

    wait (pending_pairs.size() == 0 && !in_valid_i);
    wait (expected_points.size() == 0);
    repeat (LATENCY + 5) @(posedge clk_i);
    if (errors == 0 && expected_points.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
